// ===== src/bgl_pkg.sv =====
// Shared types and constants for the button gesture LED controller.
// No dependencies.
package bgl_pkg;

  localparam int unsigned CfgW     = 10;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned PatternW = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_LONG_A  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_B  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DCLK_WIN = 2'd2;

  localparam logic [CfgW-1:0] LONG_A_RST   = 10'd50;
  localparam logic [CfgW-1:0] LONG_B_RST   = 10'd100;
  localparam logic [CfgW-1:0] DCLK_WIN_RST = 10'd100;

  localparam logic [CfgW-1:0]     HOLD_MAX  = 10'd1023;
  localparam logic [TimerW-1:0]   TIMER_MAX = 16'hFFFF;
  localparam logic [PatternW-1:0] TOP_BIT   = 8'h80;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_LONG     = 2'd3;

  typedef struct packed {
    logic idle;       // released and level high: timer advances
    logic short_rel;  // pressed -> released
    logic long_rel;   // long -> released
  } btn_evt_t;

endpackage

// ===== src/bgl_button.sv =====
// Per-button phase machine with hold counter.
// Depends on bgl_pkg.
module bgl_button (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic                      low_i,
  input  logic [bgl_pkg::CfgW-1:0]  threshold_i,
  input  logic                      hold_clr_i,
  output bgl_pkg::btn_evt_t         evt_o
);
  import bgl_pkg::*;

  logic [1:0]      phase_q, phase_d;
  logic [CfgW-1:0] hold_q, hold_d, hold_inc;

  always_comb begin
    phase_d  = phase_q;
    hold_d   = hold_q;
    evt_o    = '0;
    hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 1'b1;
    case (phase_q)
      PH_RELEASED: begin
        if (low_i) begin
          phase_d = PH_DEBOUNCE;
        end else begin
          evt_o.idle = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        phase_d = low_i ? PH_PRESSED : PH_RELEASED;
      end
      PH_PRESSED: begin
        if (low_i) begin
          hold_d = hold_inc;
          if (hold_inc > threshold_i) begin
            phase_d = PH_LONG;
          end
        end else begin
          phase_d         = PH_RELEASED;
          hold_d          = '0;
          evt_o.short_rel = 1'b1;
        end
      end
      default: begin
        if (!low_i) begin
          phase_d        = PH_RELEASED;
          hold_d         = '0;
          evt_o.long_rel = 1'b1;
        end
      end
    endcase
    if (hold_clr_i) begin
      hold_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RELEASED;
      hold_q  <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
    end
  end

endmodule

// ===== src/bgl_gesture.sv =====
// Click timer, pending-click flag and LED pattern register.
// Depends on bgl_pkg.
module bgl_gesture (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic                         load_i,
  input  logic [bgl_pkg::PatternW-1:0] switch_i,
  input  logic [bgl_pkg::CfgW-1:0]     window_i,
  input  bgl_pkg::btn_evt_t            evt_a_i,
  input  bgl_pkg::btn_evt_t            evt_b_i,
  output logic                         hold_clr_a_o,
  output logic [bgl_pkg::PatternW-1:0] pattern_o
);
  import bgl_pkg::*;

  logic                pending_q, pending_d;
  logic [TimerW-1:0]   timer_q, timer_d, timer_adv;
  logic [TimerW:0]     timer_sum;
  logic [TimerW-1:0]   window;
  logic [PatternW-1:0] pattern_q, pattern_d;
  logic                timeout;

  always_comb begin
    timer_sum = {1'b0, timer_q} + {{TimerW{1'b0}}, evt_a_i.idle}
                + {{TimerW{1'b0}}, evt_b_i.idle};
    timer_adv = timer_sum[TimerW] ? TIMER_MAX : timer_sum[TimerW-1:0];
    window    = {{(TimerW-CfgW){1'b0}}, window_i};
    timeout   = pending_q && (timer_adv > window);

    pending_d    = pending_q;
    timer_d      = timer_adv;
    pattern_d    = pattern_q;
    hold_clr_a_o = 1'b0;

    if (evt_a_i.short_rel || timeout) begin
      hold_clr_a_o = 1'b1;
      if (pending_q) begin
        if (timer_adv < window) begin
          pattern_d = {pattern_q[0], pattern_q[PatternW-1:1]};
        end else begin
          pattern_d = {pattern_q[PatternW-2:0], pattern_q[PatternW-1]};
        end
        pending_d = 1'b0;
      end else begin
        pending_d = 1'b1;
        timer_d   = '0;
      end
    end else if (evt_a_i.long_rel) begin
      pattern_d = ~pattern_q;
      pending_d = 1'b0;
    end else if (evt_b_i.long_rel) begin
      pattern_d = pattern_q ^ TOP_BIT;
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      timer_q   <= '0;
      pattern_q <= '0;
    end else if (load_i) begin
      pattern_q <= switch_i;
    end else if (tick_i) begin
      pending_q <= pending_d;
      timer_q   <= timer_d;
      pattern_q <= pattern_d;
    end
  end

  assign pattern_o = pattern_q;

endmodule

// ===== src/button_gesture_led_control.sv =====
// Usage notes
// Input channel (in_valid_i / in_ready_o) carries one item per transaction:
// operation_i selects a sample tick (button levels, active low) or a load of
// switch_value_i into the LED pattern. Every item gives exactly one result
// on the output channel (out_valid_o / out_ready_o side: out_ready_i), the
// LED pattern after the item.
// Items pass an input register, then one pass of phase-machine and gesture
// logic into the pattern / result register. With out_ready_i high, one item
// per cycle is sustained; the input register frees as soon as the result
// register is empty or being taken, so a stalled receiver holds at most two
// items. Config writes (cfg_valid_i / cfg_ready_o) are always taken; index
// 0 and 1 set the long-press thresholds of buttons A and B, index 2 the
// double-click window; other indexes are ignored. Write only while idle.
// Reset: buttons released, counters and timer zero, no pending click,
// pattern zero, thresholds 50 / 100 and window 100.
// Top level; depends on bgl_pkg, bgl_button and bgl_gesture.
module button_gesture_led_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic                            button_a_level_i,
  input  logic                            button_b_level_i,
  input  logic [bgl_pkg::PatternW-1:0]    switch_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bgl_pkg::PatternW-1:0]    led_pattern_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bgl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bgl_pkg::CfgW-1:0]        cfg_data_i
);
  import bgl_pkg::*;

  logic [CfgW-1:0]     long_a_q, long_b_q, window_q;
  logic                s1_valid_q, out_valid_q;
  logic                op_q, a_lvl_q, b_lvl_q;
  logic [PatternW-1:0] sw_q;
  logic                fire, tick, load, hold_clr_a;
  btn_evt_t            evt_a, evt_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_a_q <= LONG_A_RST;
      long_b_q <= LONG_B_RST;
      window_q <= DCLK_WIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_A:   long_a_q <= cfg_data_i;
        CFG_LONG_B:   long_b_q <= cfg_data_i;
        CFG_DCLK_WIN: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign tick       = fire && (op_q == OP_TICK);
  assign load       = fire && (op_q == OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      a_lvl_q <= button_a_level_i;
      b_lvl_q <= button_b_level_i;
      sw_q    <= switch_value_i;
    end
  end

  bgl_button u_btn_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .low_i       (!a_lvl_q),
    .threshold_i (long_a_q),
    .hold_clr_i  (hold_clr_a),
    .evt_o       (evt_a)
  );

  bgl_button u_btn_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .low_i       (!b_lvl_q),
    .threshold_i (long_b_q),
    .hold_clr_i  (1'b0),
    .evt_o       (evt_b)
  );

  bgl_gesture u_gesture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .load_i       (load),
    .switch_i     (sw_q),
    .window_i     (window_q),
    .evt_a_i      (evt_a),
    .evt_b_i      (evt_b),
    .hold_clr_a_o (hold_clr_a),
    .pattern_o    (led_pattern_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/sv/led_pattern_checker.sv =====
// Checker for button_gesture_led_control: watches the item, result and config channels,
// predicts the LED pattern of every accepted item and compares it in order.
// Depends on bgl_pkg.
`timescale 1ns / 100ps

module led_pattern_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        operation_i,
  input  logic                        button_a_level_i,
  input  logic                        button_b_level_i,
  input  logic [bgl_pkg::PatternW-1:0] switch_value_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bgl_pkg::PatternW-1:0] led_pattern_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [bgl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bgl_pkg::CfgW-1:0]     cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          item_count_o,
  output int                          load_count_o,
  output int                          single_count_o,
  output int                          double_count_o,
  output int                          invert_count_o,
  output int                          toggle_count_o
);
  import bgl_pkg::*;

  localparam int MAX_REPORTS = 20;

  logic [1:0]          phase_q      [2];
  logic [1:0]          prev_phase_q [2];
  logic [CfgW-1:0]     hold_q       [2];
  logic                click_pend;
  logic [TimerW-1:0]   click_tmr;
  logic [PatternW-1:0] pattern_q;
  logic [CfgW-1:0]     long_a, long_b, dclk_win;
  logic [PatternW-1:0] led_pattern_q [$];

  function automatic void clear_model();
    for (int b = 0; b < 2; b++) begin
      phase_q[b]      = PH_RELEASED;
      prev_phase_q[b] = PH_RELEASED;
      hold_q[b]       = '0;
    end
    click_pend     = 1'b0;
    click_tmr      = '0;
    pattern_q      = '0;
    long_a         = LONG_A_RST;
    long_b         = LONG_B_RST;
    dclk_win       = DCLK_WIN_RST;
    led_pattern_q.delete();
    fail_count_o   = 0;
    pending_o      = 0;
    item_count_o   = 0;
    load_count_o   = 0;
    single_count_o = 0;
    double_count_o = 0;
    invert_count_o = 0;
    toggle_count_o = 0;
  endfunction

  function automatic void advance_button(input int b, input logic low,
                                         input logic [CfgW-1:0] limit);
    case (phase_q[b])
      PH_RELEASED: begin
        if (low) phase_q[b] = PH_DEBOUNCE;
        else if (click_tmr != TIMER_MAX) click_tmr = click_tmr + 1'b1;
      end
      PH_DEBOUNCE: phase_q[b] = low ? PH_PRESSED : PH_RELEASED;
      PH_PRESSED: begin
        if (low) begin
          if (hold_q[b] != HOLD_MAX) hold_q[b] = hold_q[b] + 1'b1;
          if (hold_q[b] > limit) phase_q[b] = PH_LONG;
        end else begin
          phase_q[b] = PH_RELEASED;
          hold_q[b]  = '0;
        end
      end
      default: begin
        if (!low) begin
          phase_q[b] = PH_RELEASED;
          hold_q[b]  = '0;
        end
      end
    endcase
  endfunction

  function automatic logic [PatternW-1:0] next_led_pattern(input logic op, input logic a_lvl,
                                                           input logic b_lvl,
                                                           input logic [PatternW-1:0] sw);
    logic a_short, a_long_rel, b_long_rel, timeout;
    item_count_o++;
    if (op == OP_LOAD) begin
      pattern_q = sw;
      load_count_o++;
    end else begin
      advance_button(0, !a_lvl, long_a);
      advance_button(1, !b_lvl, long_b);
      a_short    = phase_q[0] == PH_RELEASED && prev_phase_q[0] == PH_PRESSED;
      a_long_rel = phase_q[0] == PH_RELEASED && prev_phase_q[0] == PH_LONG;
      b_long_rel = phase_q[1] == PH_RELEASED && prev_phase_q[1] == PH_LONG;
      timeout    = click_pend && (click_tmr > TimerW'(dclk_win));
      if (a_short || timeout) begin
        if (click_pend) begin
          if (click_tmr < TimerW'(dclk_win)) begin
            pattern_q = {pattern_q[0], pattern_q[PatternW-1:1]};
            double_count_o++;
          end else begin
            pattern_q = {pattern_q[PatternW-2:0], pattern_q[PatternW-1]};
            single_count_o++;
          end
          click_pend = 1'b0;
        end else begin
          click_pend = 1'b1;
          click_tmr  = '0;
        end
        hold_q[0] = '0;
      end else if (a_long_rel) begin
        pattern_q  = ~pattern_q;
        click_pend = 1'b0;
        invert_count_o++;
      end else if (b_long_rel) begin
        pattern_q  = pattern_q ^ TOP_BIT;
        click_pend = 1'b0;
        toggle_count_o++;
      end
      prev_phase_q[0] = phase_q[0];
      prev_phase_q[1] = phase_q[1];
    end
    return pattern_q;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [PatternW-1:0] expected;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LONG_A:   long_a   = cfg_data_i;
          CFG_LONG_B:   long_b   = cfg_data_i;
          CFG_DCLK_WIN: dclk_win = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (led_pattern_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: led_pattern transaction with nothing expected: expected none, actual %h",
                     $time, led_pattern_i);
        end else begin
          expected = led_pattern_q.pop_front();
          if (led_pattern_i !== expected) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display("%0t: led_pattern mismatch: expected %h, actual %h",
                       $time, expected, led_pattern_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        led_pattern_q.push_back(next_led_pattern(operation_i, button_a_level_i,
                                                 button_b_level_i, switch_value_i));
      pending_o = led_pattern_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the button_gesture_led_control testbench: clock, reset, item and config stimulus
// with random sender bursts and receiver stalls, watchdog and verdict.
// Depends on bgl_pkg, led_pattern_checker and the block under test.
`timescale 1ns / 100ps

module testbench;
  import bgl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 8;
  localparam int PHASE_ITEMS    = 50;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  logic                clk, rst_n;
  logic                in_valid, in_ready, operation, btn_a, btn_b;
  logic [PatternW-1:0] switches, led_pattern;
  logic                out_valid, out_ready;
  logic                cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  int fail_count, pending, item_count, load_count;
  int single_count, double_count, invert_count, toggle_count;
  int burst_left     = 0;
  int idle_cycles    = 0;
  int settings_count = 0;
  int items_sent     = 0;
  int rx_mode        = 0;
  int rx_left        = 0;
  int cur_a, cur_b, cur_win;

  button_gesture_led_control uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .button_a_level_i(btn_a),
    .button_b_level_i(btn_b),
    .switch_value_i  (switches),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .led_pattern_o   (led_pattern),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  led_pattern_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .button_a_level_i(btn_a),
    .button_b_level_i(btn_b),
    .switch_value_i  (switches),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .led_pattern_i   (led_pattern),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .item_count_o    (item_count),
    .load_count_o    (load_count),
    .single_count_o  (single_count),
    .double_count_o  (double_count),
    .invert_count_o  (invert_count),
    .toggle_count_o  (toggle_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: ready pattern switches between free flow, coin flip and heavy stall
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'($urandom_range(0, 1));
      default: out_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL button_gesture_led_control");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int a, input int b, input int w);
    cur_a   = a;
    cur_b   = b;
    cur_win = w;
    write_reg(CFG_LONG_A, CfgW'(a));
    write_reg(CFG_LONG_B, CfgW'(b));
    write_reg(CFG_DCLK_WIN, CfgW'(w));
    settings_count++;
  endtask

  task automatic drive_item(input logic op, input logic a, input logic b,
                            input logic [PatternW-1:0] sw);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    btn_a     = a;
    btn_b     = b;
    switches  = sw;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_tick(input logic a, input logic b);
    drive_item(OP_TICK, a, b, PatternW'($urandom));
  endtask

  task automatic send_load(input logic [PatternW-1:0] v);
    drive_item(OP_LOAD, 1'($urandom), 1'($urandom), v);
  endtask

  // hold the chosen buttons down for low_n ticks, then release everything for high_n
  task automatic press_pattern(input logic use_a, input logic use_b,
                               input int low_n, input int high_n);
    repeat (low_n) send_tick(!use_a, !use_b);
    repeat (high_n) send_tick(1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic int hold_len(input int limit);
    if ($urandom_range(0, 3) == 0 && limit < 120) return limit + $urandom_range(0, 3);
    return $urandom_range(1, 6);
  endfunction

  function automatic int gap_len();
    return $urandom_range(0, (cur_win < 80) ? cur_win / 2 + 3 : 12);
  endfunction

  task automatic run_gestures(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: press_pattern(1'b1, 1'b0, hold_len(cur_a), gap_len());
        4: begin
          press_pattern(1'b1, 1'b0, $urandom_range(2, 4), $urandom_range(0, 2));
          press_pattern(1'b1, 1'b0, $urandom_range(1, 4), gap_len());
        end
        5, 6: press_pattern(1'b0, 1'b1, hold_len(cur_b), gap_len());
        7: press_pattern(1'b1, 1'b1, hold_len((cur_a < cur_b) ? cur_a : cur_b), gap_len());
        8: send_load(PatternW'($urandom));
        default: repeat ($urandom_range(1, 6))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    operation = OP_TICK;
    btn_a     = 1'b1;
    btn_b     = 1'b1;
    switches  = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LONG_A;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: loads, click timeout, double click, release at the window, long presses
    set_config(1, 1, 4);
    send_load(8'h00);
    send_load(8'hFF);
    send_load(8'h81);
    press_pattern(1'b1, 1'b0, 2, 4);
    press_pattern(1'b1, 1'b0, 2, 1);
    press_pattern(1'b1, 1'b0, 2, 1);
    press_pattern(1'b1, 1'b0, 2, 1);
    press_pattern(1'b1, 1'b0, 3, 1);
    press_pattern(1'b1, 1'b0, 4, 1);
    press_pattern(1'b0, 1'b1, 4, 1);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(int'(LONG_A_RST), int'(LONG_B_RST), int'(DCLK_WIN_RST));
        1: set_config(1, 1, 1);
        2: begin
          write_reg(CFG_UNUSED, CfgW'($urandom));
          set_config($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(2, 12));
        end
        3: set_config(1000, 1000, 1000);
        4: set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(4, 30));
        5: set_config(1, 1000, $urandom_range(1, 3));
        default: set_config($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 60));
      endcase
      run_gestures(PHASE_ITEMS);
      wait_drained();
    end

    // B at the top of the threshold range stays pressed while A goes long
    set_config(3, 1023, 1000);
    press_pattern(1'b1, 1'b1, 20, 4);
    press_pattern(1'b1, 1'b0, 3, 2);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d items (%0d loads) under %0d register settings.",
             item_count, load_count, settings_count);
    $display("Gestures seen: %0d single, %0d double, %0d invert, %0d top-bit toggle.",
             single_count, double_count, invert_count, toggle_count);
    if (pending != 0)
      $display("%0t: %0d expected LED patterns never arrived", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("PASS button_gesture_led_control");
    else
      $display("FAIL button_gesture_led_control");
    $finish;
  end

endmodule
